// File: src/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared codes, widths and types of the variable file calculator: command
// and status codes, fixed port widths and the ALU control word.
// ----------------------------------------------------------------------------
package vfc_pkg;

  // Fixed field widths of the command and result words
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 5;
  localparam int IMM_W    = 31;
  localparam int STATUS_W = 2;
  localparam int PVAL_W   = 32;

  // Widest data path supported, used for zero-extension before a select
  localparam int MAX_DW   = 64;
  // Index width after zero-extension, wide enough to compare against 64
  localparam int IDX_EXT_W = 7;

  // Command codes
  localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUB   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUL   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DIV   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PRINT = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRINTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd2;

  // Operations of the shared ALU
  typedef enum logic [2:0] {
    ALU_SET,
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Control word from the sequencer to the ALU
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctrl_t;

endpackage

// File: src/variable_file_calculator_unit.sv
// ----------------------------------------------------------------------------
// variable_file_calculator_unit
// Register file of signed variables with a shared iterative ALU: set, add,
// subtract, multiply, divide and print, one command at a time.
//
//   Channel   Direction  Handshake              Word
//   command   in         start high, busy low   req_type, dest_index,
//                                               operand_is_variable,
//                                               source_index, immediate_value
//   result    out        done strobe, 1 cycle   status, print_value
//
// Print, divide by zero and unused codes retire without the ALU.
// Multiply and divide run in the shared ALU, one multiplier or quotient bit a cycle.
// The destination and a variable source come through the one read port of the variable RAM in turn.
// Reset clears all variables at once through per-entry valid bits.
// The result strobe cannot be stalled; busy drops in the strobe cycle.
// ----------------------------------------------------------------------------
module variable_file_calculator_unit #(
  parameter int NUM_VARIABLES = 26,
  parameter int DATA_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [vfc_pkg::REQ_W-1:0]           req_type,
  input  logic [vfc_pkg::IDX_W-1:0]           dest_index,
  input  logic                                operand_is_variable,
  input  logic [vfc_pkg::IDX_W-1:0]           source_index,
  input  logic [vfc_pkg::IMM_W-1:0]           immediate_value,
  output logic                                done,
  output logic [vfc_pkg::STATUS_W-1:0]        status,
  output logic signed [vfc_pkg::PVAL_W-1:0]   print_value
);

  import vfc_pkg::*;

  localparam int ADDR_W = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_LOAD,
    S_RUN
  } state_t;

  state_t                   state;
  logic [REQ_W-1:0]         req;
  logic                     is_var;
  logic [ADDR_W-1:0]        dest_addr;
  logic                     dest_ok;
  logic [ADDR_W-1:0]        src_addr;
  logic                     src_ok;
  logic [DATA_WIDTH-1:0]    imm;
  logic [DATA_WIDTH-1:0]    a_val;
  logic [NUM_VARIABLES-1:0] valid;

  logic [IDX_EXT_W-1:0]     dest_ext;
  logic [IDX_EXT_W-1:0]     src_ext;
  logic [MAX_DW-1:0]        imm_wide;
  logic [MAX_DW-1:0]        a_wide;

  logic                     wr_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_WIDTH-1:0]    rd_data;
  logic [DATA_WIDTH-1:0]    rd_word;
  logic [DATA_WIDTH-1:0]    b_val;

  alu_ctrl_t                alu_ctrl;
  logic                     alu_done;
  logic [DATA_WIDTH-1:0]    alu_result;

  // Extend indexes and the immediate to fixed widths before selecting bits
  assign dest_ext = IDX_EXT_W'(dest_index);
  assign src_ext  = IDX_EXT_W'(source_index);
  assign imm_wide = MAX_DW'(immediate_value);
  assign a_wide   = MAX_DW'(a_val);

  assign busy = (state != S_IDLE);

  // Read the destination first, then the source
  assign rd_addr = (state == S_READ_A) ? dest_addr : src_addr;

  // Mask entries never written since reset, and indexes past the file
  always_comb begin
    rd_word = '0;
    if (state == S_READ_B) begin
      rd_word = (dest_ok && valid[dest_addr]) ? rd_data : '0;
    end else begin
      rd_word = (src_ok && valid[src_addr]) ? rd_data : '0;
    end
    b_val = is_var ? rd_word : imm;
  end

  // Decode the command into an ALU operation
  always_comb begin
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_SET;
    case (req)
      REQ_SET: alu_ctrl.op = ALU_SET;
      REQ_ADD: alu_ctrl.op = ALU_ADD;
      REQ_SUB: alu_ctrl.op = ALU_SUB;
      REQ_MUL: alu_ctrl.op = ALU_MUL;
      REQ_DIV: alu_ctrl.op = ALU_DIV;
      default: alu_ctrl.op = ALU_SET;
    endcase
    if (state == S_LOAD) begin
      case (req)
        REQ_SET, REQ_ADD, REQ_SUB, REQ_MUL: alu_ctrl.start = 1'b1;
        REQ_DIV: alu_ctrl.start = (b_val != '0);
        default: alu_ctrl.start = 1'b0;
      endcase
    end
  end

  // Write back the ALU result to an in-range destination
  assign wr_en = (state == S_RUN) && alu_done && dest_ok;

  // Sequence one command and hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req       <= req_type;
            is_var    <= operand_is_variable;
            dest_addr <= dest_ext[ADDR_W-1:0];
            dest_ok   <= dest_ext < IDX_EXT_W'(NUM_VARIABLES);
            src_addr  <= src_ext[ADDR_W-1:0];
            src_ok    <= src_ext < IDX_EXT_W'(NUM_VARIABLES);
            imm       <= imm_wide[DATA_WIDTH-1:0];
            state     <= S_READ_A;
          end
        end
        S_READ_A: begin
          state <= S_READ_B;
        end
        S_READ_B: begin
          a_val <= rd_word;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (alu_ctrl.start) begin
            state <= S_RUN;
          end else begin
            done        <= 1'b1;
            print_value <= '0;
            state       <= S_IDLE;
            case (req)
              REQ_PRINT: begin
                status      <= ST_PRINTED;
                print_value <= a_wide[PVAL_W-1:0];
              end
              REQ_DIV: status <= ST_DIV_ZERO;
              default: status <= ST_DONE;
            endcase
          end
        end
        S_RUN: begin
          if (alu_done) begin
            if (dest_ok) begin
              valid[dest_addr] <= 1'b1;
            end
            done        <= 1'b1;
            status      <= ST_DONE;
            print_value <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  vfc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_VARIABLES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (dest_addr),
    .wr_data (alu_result),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  vfc_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .opa_in (a_val),
    .opb_in (b_val),
    .done   (alu_done),
    .result (alu_result)
  );

  // The result word goes out only as the command retires
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is in flight");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted without going busy");

  // Only a print carries a value
  a_pval_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_PRINTED |-> print_value == '0)
    else $error("nonzero print value on a non-print result");

  // The ALU finishes only while the sequencer waits on it
  a_alu_run: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_RUN)
    else $error("ALU completion outside the run state");

  // The file is written only on ALU completion
  a_write_run: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> alu_done && dest_ok)
    else $error("variable write without ALU completion");

endmodule

// File: src/vfc_ram.sv
// ----------------------------------------------------------------------------
// vfc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 26
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word; the read word is registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/vfc_alu.sv
// ----------------------------------------------------------------------------
// vfc_alu
// Shared ALU built around one adder/subtractor. Set, add and subtract take
// one pass; multiply runs shift-and-add one bit a cycle; divide takes the
// operand magnitudes, runs restoring division one quotient bit a cycle and
// fixes the sign in the final pass.
// ----------------------------------------------------------------------------
module vfc_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vfc_pkg::alu_ctrl_t        ctrl,
  input  logic [DATA_WIDTH-1:0]     opa_in,
  input  logic [DATA_WIDTH-1:0]     opb_in,
  output logic                      done,
  output logic [DATA_WIDTH-1:0]     result
);

  import vfc_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int SUM_W = DATA_WIDTH + 1;

  typedef enum logic [2:0] {
    A_IDLE,
    A_NEG_A,
    A_NEG_B,
    A_STEP,
    A_FIN
  } astate_t;

  astate_t               state;
  alu_op_t               op;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [DATA_WIDTH-1:0] acc;
  logic [CNT_W-1:0]      cnt;
  logic                  neg_q;

  logic [SUM_W-1:0]      add_x;
  logic [SUM_W-1:0]      add_y;
  logic                  add_sub;
  logic [SUM_W-1:0]      sum;
  logic [DATA_WIDTH-1:0] shifted;

  // Partial remainder shifted left with the next dividend bit
  assign shifted = {acc[DATA_WIDTH-2:0], opa[DATA_WIDTH-1]};

  // Select operands of the one shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      A_NEG_A: begin
        add_y   = {1'b0, opa};
        add_sub = 1'b1;
      end
      A_NEG_B: begin
        add_y   = {1'b0, opb};
        add_sub = 1'b1;
      end
      A_STEP: begin
        if (op == ALU_MUL) begin
          add_x = {1'b0, acc};
          add_y = opb[0] ? {1'b0, opa} : '0;
        end else begin
          add_x   = {1'b0, shifted};
          add_y   = {1'b0, opb};
          add_sub = 1'b1;
        end
      end
      A_FIN: begin
        case (op)
          ALU_SET: begin
            add_y = {1'b0, opb};
          end
          ALU_ADD: begin
            add_x = {1'b0, opa};
            add_y = {1'b0, opb};
          end
          ALU_SUB: begin
            add_x   = {1'b0, opa};
            add_y   = {1'b0, opb};
            add_sub = 1'b1;
          end
          ALU_MUL: begin
            add_x = {1'b0, acc};
          end
          ALU_DIV: begin
            add_y   = {1'b0, opa};
            add_sub = neg_q;
          end
          default: begin
            add_x = '0;
          end
        endcase
      end
      default: begin
        add_x = '0;
      end
    endcase
    sum = add_x + (add_y ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);
  end

  // Sequence the passes through the adder
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (ctrl.start) begin
            op    <= ctrl.op;
            opa   <= opa_in;
            opb   <= opb_in;
            acc   <= '0;
            cnt   <= CNT_W'(DATA_WIDTH - 1);
            neg_q <= opa_in[DATA_WIDTH-1] ^ opb_in[DATA_WIDTH-1];
            case (ctrl.op)
              ALU_DIV: state <= A_NEG_A;
              ALU_MUL: state <= A_STEP;
              default: state <= A_FIN;
            endcase
          end
        end
        A_NEG_A: begin
          if (opa[DATA_WIDTH-1]) begin
            opa <= sum[DATA_WIDTH-1:0];
          end
          state <= A_NEG_B;
        end
        A_NEG_B: begin
          if (opb[DATA_WIDTH-1]) begin
            opb <= sum[DATA_WIDTH-1:0];
          end
          state <= A_STEP;
        end
        A_STEP: begin
          if (op == ALU_MUL) begin
            acc <= sum[DATA_WIDTH-1:0];
            opa <= {opa[DATA_WIDTH-2:0], 1'b0};
            opb <= {1'b0, opb[DATA_WIDTH-1:1]};
          end else if (!sum[DATA_WIDTH]) begin
            acc <= sum[DATA_WIDTH-1:0];
            opa <= {opa[DATA_WIDTH-2:0], 1'b1};
          end else begin
            acc <= shifted;
            opa <= {opa[DATA_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          result <= sum[DATA_WIDTH-1:0];
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  // A new operation is only started while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> state == A_IDLE)
    else $error("ALU started while busy");

  // Completion is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("ALU done held for more than one cycle");

endmodule
